// ----- src/dxtd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dxtd_pkg
// Types, constants and small arithmetic helpers shared by the DXT block
// decoder pipeline.
// ----------------------------------------------------------------------------
package dxtd_pkg;

   localparam int unsigned NumRows    = 4;
   localparam int unsigned NumCols    = 4;
   localparam logic [7:0]  AlphaOpaque = 8'hFF;

   localparam logic ModeDxt1 = 1'b0;
   localparam logic ModeDxt3 = 1'b1;

   typedef struct packed {
      logic [7:0] b;
      logic [7:0] g;
      logic [7:0] r;
   } rgb_type;

   // stage 1 result: expanded endpoints plus the block's raw index/alpha bits
   typedef struct packed {
      rgb_type     c0;
      rgb_type     c1;
      logic        four;
      logic        mode;
      logic [31:0] idx;
      logic [63:0] alpha;
   } s1_type;

   // stage 2 result: full RGBA palette
   typedef struct packed {
      logic [3:0][31:0] pal;
      logic             mode;
      logic [31:0]      idx;
      logic [63:0]      alpha;
   } s2_type;

   typedef struct packed {
      logic [3:0][31:0] pixel;
      logic [1:0]       row;
      logic             last;
   } row_type;

   // v*255/31 truncated = 8v + floor(7v/31)
   function automatic logic [7:0] expand5(input logic [4:0] v);
      logic [7:0] t;
      logic [2:0] q;
      t = {v, 3'b000} - {3'b000, v};
      q = 3'd0;
      for (int k = 1; k <= 7; k++) begin
         if (t >= 8'(31 * k)) begin
            q = q + 3'd1;
         end
      end
      return {v, 3'b000} + {5'b00000, q};
   endfunction

   // v*255/63 truncated = 4v + floor(v/21)
   function automatic logic [7:0] expand6(input logic [5:0] v);
      logic [1:0] q;
      q = 2'd0;
      if (v >= 6'd21) q = q + 2'd1;
      if (v >= 6'd42) q = q + 2'd1;
      if (v >= 6'd63) q = q + 2'd1;
      return {v, 2'b00} + {6'b000000, q};
   endfunction

   // x/3 for x < 768: multiply by reciprocal 683/2048
   function automatic logic [7:0] div3(input logic [9:0] x);
      logic [20:0] p;
      p = 21'(x) * 21'd683;
      return p[18:11];
   endfunction

endpackage
`default_nettype wire

// ----- src/dxt_block_decoder_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dxt_block_decoder_core
// The first row appears after the expand, palette, row-emitter and result registers; rows follow on consecutive cycles.
// New blocks are held off while the single row emitter port is in use.
// busy stays high after each accepted block until the row emitter can take the next; results cannot stall.
// Synchronous reset clears the pipeline valids and alpha_mode (DXT1).
// ----------------------------------------------------------------------------
module dxt_block_decoder_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [63:0] req_color_word,
   input  wire logic [63:0] req_alpha_word,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_wdata,
   output logic             rsp_strobe,
   output logic [31:0]      rsp_pixel_left,
   output logic [31:0]      rsp_pixel_second,
   output logic [31:0]      rsp_pixel_third,
   output logic [31:0]      rsp_pixel_right,
   output logic [1:0]       rsp_row_number,
   output logic             rsp_last_row
);
   import dxtd_pkg::*;

   logic       mode_ff;
   logic [1:0] gap_ff, gap_in;
   logic       accept;
   logic       s1_valid, s2_valid;
   s1_type     s1_data;
   s2_type     s2_data;
   row_type    rsp_data;

   assign accept    = start && !busy;
   assign busy      = (gap_ff != 2'd0);
   assign csr_ready = 1'b1;

   // hold off new blocks until the row emitter frees up
   always_comb begin
      gap_in = gap_ff;
      if (accept) begin
         gap_in = 2'(NumRows - 1);
      end else if (gap_ff != 2'd0) begin
         gap_in = gap_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff  <= 2'd0;
         mode_ff <= ModeDxt1;
      end else begin
         gap_ff <= gap_in;
         if (csr_valid && csr_ready) begin
            mode_ff <= csr_wdata;
         end
      end
   end

   dxtd_expand u_expand (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (accept),
      .color_word (req_color_word),
      .alpha_word (req_alpha_word),
      .mode       (mode_ff),
      .out_valid  (s1_valid),
      .out_data   (s1_data)
   );

   dxtd_palette u_palette (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_data  (s2_data)
   );

   dxtd_row_emit u_row_emit (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s2_valid),
      .in_data    (s2_data),
      .out_strobe (rsp_strobe),
      .out_data   (rsp_data)
   );

   assign rsp_pixel_left   = rsp_data.pixel[0];
   assign rsp_pixel_second = rsp_data.pixel[1];
   assign rsp_pixel_third  = rsp_data.pixel[2];
   assign rsp_pixel_right  = rsp_data.pixel[3];
   assign rsp_row_number   = rsp_data.row;
   assign rsp_last_row     = rsp_data.last;

endmodule
`default_nettype wire

// ----- src/dxtd_expand.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dxtd_expand
// Stage 1: unpack both RGB565 endpoints to 8-bit channels and pick the
// palette mode.
// ----------------------------------------------------------------------------
module dxtd_expand (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   input  wire logic [63:0]     color_word,
   input  wire logic [63:0]     alpha_word,
   input  wire logic            mode,
   output logic                 out_valid,
   output dxtd_pkg::s1_type     out_data
);
   import dxtd_pkg::*;

   logic   valid_ff;
   s1_type data_ff, data_in;
   logic [15:0] e0, e1;

   always_comb begin
      e0 = color_word[15:0];
      e1 = color_word[31:16];
      data_in.c0.r  = expand5(e0[15:11]);
      data_in.c0.g  = expand6(e0[10:5]);
      data_in.c0.b  = expand5(e0[4:0]);
      data_in.c1.r  = expand5(e1[15:11]);
      data_in.c1.g  = expand6(e1[10:5]);
      data_in.c1.b  = expand5(e1[4:0]);
      data_in.four  = (mode == ModeDxt3) || (e0 > e1);
      data_in.mode  = mode;
      data_in.idx   = color_word[63:32];
      data_in.alpha = alpha_word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

// ----- src/dxtd_palette.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dxtd_palette
// Stage 2: build the four RGBA palette entries from the expanded endpoints.
// ----------------------------------------------------------------------------
module dxtd_palette (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   input  wire dxtd_pkg::s1_type in_data,
   output logic                 out_valid,
   output dxtd_pkg::s2_type     out_data
);
   import dxtd_pkg::*;

   logic   valid_ff;
   s2_type data_ff, data_in;
   rgb_type c0, c1, a, b, m;

   function automatic logic [7:0] blend(input logic [7:0] x, input logic [7:0] y);
      return div3({1'b0, x, 1'b0} + {2'b00, y});
   endfunction

   function automatic logic [7:0] avg(input logic [7:0] x, input logic [7:0] y);
      logic [8:0] s;
      s = {1'b0, x} + {1'b0, y};
      return s[8:1];
   endfunction

   always_comb begin
      c0 = in_data.c0;
      c1 = in_data.c1;
      a.r = blend(c0.r, c1.r);
      a.g = blend(c0.g, c1.g);
      a.b = blend(c0.b, c1.b);
      b.r = blend(c1.r, c0.r);
      b.g = blend(c1.g, c0.g);
      b.b = blend(c1.b, c0.b);
      m.r = avg(c0.r, c1.r);
      m.g = avg(c0.g, c1.g);
      m.b = avg(c0.b, c1.b);

      data_in.pal[0] = {AlphaOpaque, c0};
      data_in.pal[1] = {AlphaOpaque, c1};
      if (in_data.four) begin
         data_in.pal[2] = {AlphaOpaque, a};
         data_in.pal[3] = {AlphaOpaque, b};
      end else begin
         // three-color block: index 3 is transparent black
         data_in.pal[2] = {AlphaOpaque, m};
         data_in.pal[3] = 32'h0000_0000;
      end
      data_in.mode  = in_data.mode;
      data_in.idx   = in_data.idx;
      data_in.alpha = in_data.alpha;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

// ----- src/dxtd_row_emit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dxtd_row_emit
// Stage 3: hold one block's palette and emit its four rows, one per cycle,
// through a registered result port.
// ----------------------------------------------------------------------------
module dxtd_row_emit (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   input  wire dxtd_pkg::s2_type in_data,
   output logic                 out_strobe,
   output dxtd_pkg::row_type    out_data
);
   import dxtd_pkg::*;

   s2_type     hold_ff;
   logic       active_ff, active_in;
   logic [1:0] row_ff, row_in;
   logic       strobe_ff;
   row_type    rsp_ff, rsp_in;

   always_comb begin
      logic [4:0] ip;
      logic [5:0] ap;
      logic [1:0] sel;
      logic [31:0] px;
      for (int c = 0; c < NumCols; c++) begin
         ip  = {row_ff, 2'(c), 1'b0};
         ap  = {row_ff, 2'(c), 2'b00};
         sel = hold_ff.idx[ip +: 2];
         px  = hold_ff.pal[sel];
         if (hold_ff.mode == ModeDxt3) begin
            px[31:24] = {hold_ff.alpha[ap +: 4], 4'b0000};
         end
         rsp_in.pixel[c] = px;
      end
      rsp_in.row  = row_ff;
      rsp_in.last = (row_ff == 2'(NumRows - 1));
   end

   always_comb begin
      active_in = active_ff;
      row_in    = row_ff;
      if (active_ff) begin
         row_in = row_ff + 2'd1;
         if (row_ff == 2'(NumRows - 1)) begin
            active_in = 1'b0;
         end
      end
      if (in_valid) begin
         active_in = 1'b1;
         row_in    = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         row_ff    <= 2'd0;
         strobe_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         row_ff    <= row_in;
         strobe_ff <= active_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         hold_ff <= in_data;
      end
      if (active_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_strobe = strobe_ff;
   assign out_data   = rsp_ff;

endmodule
`default_nettype wire

// ----- bench/dxt_row_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dxt_row_checker
// Watches the block, configuration and row channels of the DXT block decoder,
// tracks the alpha mode from accepted register writes, predicts the four RGBA
// rows of every accepted block and compares each emitted row, in order,
// against the oldest prediction.
// ----------------------------------------------------------------------------
module dxt_row_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        busy,
   input  wire logic [63:0] color_word,
   input  wire logic [63:0] alpha_word,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic        csr_wdata,
   input  wire logic        rsp_strobe,
   input  wire logic [31:0] rsp_pixel_left,
   input  wire logic [31:0] rsp_pixel_second,
   input  wire logic [31:0] rsp_pixel_third,
   input  wire logic [31:0] rsp_pixel_right,
   input  wire logic [1:0]  rsp_row_number,
   input  wire logic        rsp_last_row,
   output int unsigned      fail_count,
   output int unsigned      rows_pending
);
   import dxtd_pkg::*;

   localparam int unsigned ReportLimit = 10;

   typedef struct packed {
      logic [3:0][31:0] pixel;
      logic [1:0]       row;
      logic             last;
   } decoded_row_type;

   decoded_row_type expected_rows[$];
   decoded_row_type got;
   decoded_row_type want;
   logic            alpha_mode;
   int unsigned     errors;

   function automatic logic [7:0] widen_channel(input int unsigned v, input int unsigned full);
      return 8'((v * 255) / full);
   endfunction

   // RGB565 endpoint to {b, g, r} bytes
   function automatic logic [23:0] endpoint_rgb(input logic [15:0] c);
      return {widen_channel(32'(c[4:0]), 31), widen_channel(32'(c[10:5]), 63),
              widen_channel(32'(c[15:11]), 31)};
   endfunction

   task automatic decode_block_rows(input logic [63:0] cw, input logic [63:0] aw,
                                    input logic mode);
      logic [15:0]      e0;
      logic [15:0]      e1;
      logic [23:0]      c0;
      logic [23:0]      c1;
      logic [3:0][31:0] palette;
      logic [1:0]       sel;
      logic [31:0]      px;
      int unsigned      x;
      int unsigned      y;
      int unsigned      p;
      decoded_row_type  r;
      e0 = cw[15:0];
      e1 = cw[31:16];
      c0 = endpoint_rgb(e0);
      c1 = endpoint_rgb(e1);
      palette[0] = {AlphaOpaque, c0};
      palette[1] = {AlphaOpaque, c1};
      palette[2][31:24] = AlphaOpaque;
      palette[3][31:24] = AlphaOpaque;
      for (int ch = 0; ch < 3; ch++) begin
         x = 32'(c0[8*ch +: 8]);
         y = 32'(c1[8*ch +: 8]);
         if (mode == ModeDxt3 || e0 > e1) begin
            palette[2][8*ch +: 8] = 8'((2 * x + y) / 3);
            palette[3][8*ch +: 8] = 8'((x + 2 * y) / 3);
         end else begin
            palette[2][8*ch +: 8] = 8'((x + y) / 2);
         end
      end
      // three-color block: index 3 is transparent black
      if (mode != ModeDxt3 && !(e0 > e1)) begin
         palette[3] = '0;
      end
      for (int row = 0; row < NumRows; row++) begin
         for (int col = 0; col < NumCols; col++) begin
            p = row * NumCols + col;
            sel = cw[32 + 2*p +: 2];
            px = palette[sel];
            if (mode == ModeDxt3) begin
               px[31:24] = {aw[4*p +: 4], 4'h0};
            end
            r.pixel[col] = px;
         end
         r.row = 2'(row);
         r.last = (row == NumRows - 1);
         expected_rows.push_back(r);
      end
   endtask

   task automatic note_failure(input string what);
      errors++;
      if (errors <= ReportLimit) begin
         $display("%t: %s", $realtime, what);
         $display("   expected %h %h %h %h row %0d last %0b", want.pixel[0], want.pixel[1],
                  want.pixel[2], want.pixel[3], want.row, want.last);
         $display("   actual   %h %h %h %h row %0d last %0b", got.pixel[0], got.pixel[1],
                  got.pixel[2], got.pixel[3], got.row, got.last);
      end
   endtask

   initial begin
      errors = 0;
      fail_count = 0;
      rows_pending = 0;
      alpha_mode = ModeDxt1;
   end

   always @(posedge clock) begin
      if (reset) begin
         alpha_mode <= ModeDxt1;
      end else begin
         if (rsp_strobe) begin
            got.pixel = {rsp_pixel_right, rsp_pixel_third, rsp_pixel_second, rsp_pixel_left};
            got.row = rsp_row_number;
            got.last = rsp_last_row;
            if (expected_rows.size() == 0) begin
               want = '0;
               note_failure("row transaction with no block pending");
            end else begin
               want = expected_rows.pop_front();
               if (got.pixel !== want.pixel || got.row !== want.row
                   || got.last !== want.last) begin
                  note_failure("row transaction mismatch");
               end
            end
         end
         if (start && !busy) begin
            decode_block_rows(color_word, alpha_word, alpha_mode);
         end
         if (csr_valid && csr_ready) begin
            alpha_mode <= csr_wdata;
         end
      end
      fail_count <= errors;
      rows_pending <= expected_rows.size();
   end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives compressed DXT1 and DXT3 blocks into the decoder with random gaps,
// switches the alpha mode between phases and reports the verdict of the
// row checker.
// ----------------------------------------------------------------------------
module testbench;
   import dxtd_pkg::*;

   localparam int unsigned StallLimit   = 2000;
   localparam int unsigned SettleCycles = 10;
   localparam int unsigned PhaseBlocks  = 50;
   localparam int unsigned PhaseCount   = 5;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic [63:0] req_color_word = '0;
   logic [63:0] req_alpha_word = '0;
   logic        csr_valid = 1'b0;
   logic        csr_wdata = 1'b0;
   logic        busy;
   logic        csr_ready;
   logic        rsp_strobe;
   logic [31:0] rsp_pixel_left;
   logic [31:0] rsp_pixel_second;
   logic [31:0] rsp_pixel_third;
   logic [31:0] rsp_pixel_right;
   logic [1:0]  rsp_row_number;
   logic        rsp_last_row;
   int unsigned fail_count;
   int unsigned rows_pending;
   int unsigned quiet_cycles = 0;
   logic        burst = 1'b0;
   logic        first_mode;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   dxt_block_decoder_core uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_color_word   (req_color_word),
      .req_alpha_word   (req_alpha_word),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_wdata        (csr_wdata),
      .rsp_strobe       (rsp_strobe),
      .rsp_pixel_left   (rsp_pixel_left),
      .rsp_pixel_second (rsp_pixel_second),
      .rsp_pixel_third  (rsp_pixel_third),
      .rsp_pixel_right  (rsp_pixel_right),
      .rsp_row_number   (rsp_row_number),
      .rsp_last_row     (rsp_last_row)
   );

   dxt_row_checker row_check (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .color_word       (req_color_word),
      .alpha_word       (req_alpha_word),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_wdata        (csr_wdata),
      .rsp_strobe       (rsp_strobe),
      .rsp_pixel_left   (rsp_pixel_left),
      .rsp_pixel_second (rsp_pixel_second),
      .rsp_pixel_third  (rsp_pixel_third),
      .rsp_pixel_right  (rsp_pixel_right),
      .rsp_row_number   (rsp_row_number),
      .rsp_last_row     (rsp_last_row),
      .fail_count       (fail_count),
      .rows_pending     (rows_pending)
   );

   // end the run when no transaction has moved for too long
   always @(posedge clock) begin
      if ((start && !busy) || (csr_valid && csr_ready) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= StallLimit) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic int unsigned idle_length();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (burst || pick < 50) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [63:0] random_word();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [15:0] corner_endpoint();
      case ($urandom_range(0, 4))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'hF800;
         3: return 16'h07E0;
         default: return 16'h001F;
      endcase
   endfunction

   function automatic logic [63:0] random_color_word();
      logic [15:0] e0;
      logic [15:0] e1;
      logic [31:0] indices;
      e0 = 16'($urandom());
      e1 = 16'($urandom());
      indices = $urandom();
      case ($urandom_range(0, 9))
         0: e1 = e0;
         1: begin
            e0 = corner_endpoint();
            e1 = corner_endpoint();
         end
         2: e1 = e0 + 16'd1;
         3: e0 = e1 + 16'd1;
         4: indices = {16{2'($urandom_range(0, 3))}};
         default: ;
      endcase
      return {indices, e1, e0};
   endfunction

   // hold start high across back-to-back blocks; drop it only for a gap
   task automatic send_block(input logic [63:0] cw, input logic [63:0] aw);
      int unsigned gap;
      gap = idle_length();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_color_word <= cw;
      req_alpha_word <= aw;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (rows_pending != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_mode(input logic mode);
      drain();
      csr_valid <= 1'b1;
      csr_wdata <= mode;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      write_mode(ModeDxt1);
      send_block(64'h0, 64'h0);
      send_block(64'hE4E4E4E4_0000FFFF, 64'h0);
      send_block(64'hE4E4E4E4_FFFF0000, 64'hFFFFFFFF_FFFFFFFF);
      send_block(64'hE4E4E4E4_12341234, 64'h01234567_89ABCDEF);
      send_block(64'h1B1B1B1B_1233_1234, random_word());
      send_block(64'hFFFFFFFF_FFFFFFFF, 64'h0);
      send_block(64'hE4E4E4E4_07E0F800, 64'h0);
      send_block(64'hE4E4E4E4_F800001F, 64'h0);
      send_block(64'hAAAAAAAA_00010000, 64'h0);
      send_block(random_word(), random_word());

      write_mode(ModeDxt3);
      send_block(64'hFFFFFFFF_FFFFFFFF, 64'hFFFFFFFF_FFFFFFFF);
      send_block(64'h0, 64'h0);
      send_block(64'hE4E4E4E4_FFFF0000, 64'h01234567_89ABCDEF);
      send_block(64'hE4E4E4E4_0000FFFF, 64'hFEDCBA98_76543210);
      send_block(64'hE4E4E4E4_5A5A5A5A, 64'hF0F0F0F0_0F0F0F0F);
      send_block(64'h1B1B1B1B_07E0F800, 64'h0);
      send_block(64'hE4E4E4E4_001F07E0, 64'hFFFFFFFF_00000000);
      send_block(random_word(), random_word());

      first_mode = 1'($urandom_range(0, 1));
      for (int phase = 0; phase < PhaseCount; phase++) begin
         write_mode(first_mode ^ 1'(phase));
         for (int n = 0; n < PhaseBlocks; n++) begin
            if ($urandom_range(0, 15) == 0) burst = !burst;
            send_block(random_color_word(), random_word());
         end
         burst = 1'b0;
      end

      drain();
      if (fail_count == 0 && rows_pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
